// ===== rtl/ray_sphere_intersection_macros.svh =====
// assertion macros shared by the checker
`ifndef RAY_SPHERE_INTERSECTION_MACROS_SVH
`define RAY_SPHERE_INTERSECTION_MACROS_SVH

// same-cycle implication, disabled during reset
`define RSI_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ray sphere check failed");

// next-cycle implication, disabled during reset
`define RSI_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ray sphere check failed");

`endif

// ===== rtl/rsi_pkg.sv =====
// shared payload types and constants for the ray sphere intersection block
package rsi_pkg;

	localparam int CW       = 32;
	localparam int RADIUS_W = 15;

	typedef struct packed {
		logic signed [CW-1:0] origin_x;
		logic signed [CW-1:0] origin_y;
		logic signed [CW-1:0] origin_z;
		logic signed [CW-1:0] dir_x;
		logic signed [CW-1:0] dir_y;
		logic signed [CW-1:0] dir_z;
		logic signed [CW-1:0] centre_x;
		logic signed [CW-1:0] centre_y;
		logic signed [CW-1:0] centre_z;
	} req_t;

	typedef struct packed {
		logic                 hit;
		logic signed [CW-1:0] hit_distance;
	} rsp_t;

endpackage

// ===== rtl/ray_sphere_intersection.sv =====
// top level of the ray sphere intersection pipeline
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-------------------------------
//  request  | in        | req_valid / req_stall | req: origin, direction, centre
//  result   | out       | rsp_valid / rsp_stall | rsp: hit, hit_distance
//  radius   | in        | radius_we             | radius_wdata
//
//  one request per cycle while req_stall is low; the pipeline depth is dominated by
//  the two bit-serial square root pipelines and the divider pipeline
//  reset clears all stage valid bits and the output skid register, radius resets to 1
//  a stalled result moves into the skid register; requests stall only while it is full
module ray_sphere_intersection #(
	parameter int FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  rsi_pkg::req_t                  req,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output rsi_pkg::rsp_t                  rsp,
	input  logic                           radius_we,
	input  logic [rsi_pkg::RADIUS_W-1:0]   radius_wdata
);
	import rsi_pkg::*;

	localparam int W    = CW;
	localparam int OW   = 2*W + 2;
	localparam int NW   = 2*W + 1;
	localparam int PW   = 2*W + 3;
	localparam int TW   = (W + 2 > FRAC_BITS + 17) ? W + 2 : FRAC_BITS + 17;
	localparam int HX   = 2*FRAC_BITS + 2*RADIUS_W;
	localparam int HR   = HX / 2;
	localparam int CMPW = (OW > HX) ? OW : HX;

	localparam logic signed [TW:0] HI_LIM = {{(TW-W+1){1'b0}}, 1'b0, {(W-1){1'b1}}};
	localparam logic signed [TW:0] LO_LIM = {{(TW-W+1){1'b1}}, 1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] MINUS_ONE = {{(W-FRAC_BITS){1'b1}}, {FRAC_BITS{1'b0}}};

	logic                en;
	logic [RADIUS_W-1:0] radius_q;
	rsp_t                skid_q;
	logic                skid_v_q;

	logic signed [W-1:0] dir_a    [3];
	logic signed [W-1:0] org_a    [3];
	logic signed [W-1:0] cen_a    [3];

	logic                v_s1;
	logic                dz_s1;
	logic signed [W-1:0] dv_s1 [3];
	logic signed [W:0]   vc_s1 [3];

	logic                 v_s2;
	logic                 dz_s2;
	logic [2*W-1:0]       dd_s2 [3];
	logic signed [2*W:0]  pv_s2 [3];
	logic [2*W:0]         vv_s2 [3];

	logic                 v_s3;
	logic                 dz_s3;
	logic [2*W-1:0]       d2_s3;
	logic signed [PW-1:0] p_s3;
	logic [OW-1:0]        o2_s3;

	logic                 v_s4;
	logic                 dz_s4;
	logic [2*W-1:0]       d2_s4;
	logic [NW-1:0]        ap_s4;
	logic [OW-1:0]        o2_s4;

	logic                 sq1_v;
	logic [W-1:0]         sq1_root;
	logic [NW-1:0]        sq1_ap;
	logic [OW-1:0]        sq1_o2;
	logic                 sq1_dz;

	logic                 div_v;
	logic [TW-1:0]        div_q;
	logic [OW-1:0]        div_o2;
	logic                 div_dz;

	logic                 v_s5;
	logic                 dz_s5;
	logic [TW-1:0]        tc_s5;
	logic [2*TW-1:0]      t2_s5;
	logic [OW-1:0]        o2_s5;
	logic [2*RADIUS_W-1:0] r2_s5;

	logic                 v_s6;
	logic                 dz_s6;
	logic [TW-1:0]        tc_s6;
	logic [OW-1:0]        dp2_s6;
	logic [2*RADIUS_W-1:0] r2_s6;
	logic [HX-1:0]        r2full;

	logic                 v_s7;
	logic                 dz_s7;
	logic                 hit_s7;
	logic [TW-1:0]        tc_s7;
	logic [HX-1:0]        diff_s7;

	logic                 sq2_v;
	logic [HR-1:0]        sq2_root;
	logic [TW-1:0]        sq2_tc;
	logic                 sq2_hit;
	logic                 sq2_dz;

	logic signed [TW:0]   res;
	logic signed [TW:0]   res_sat;
	logic                 v_s8;
	rsp_t                 rsp_s8;

	assign en        = !skid_v_q;
	assign req_stall = skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= {{(RADIUS_W-1){1'b0}}, 1'b1};
		end else if (radius_we) begin
			radius_q <= radius_wdata;
		end
	end

	assign dir_a = '{req.dir_x, req.dir_y, req.dir_z};
	assign org_a = '{req.origin_x, req.origin_y, req.origin_z};
	assign cen_a = '{req.centre_x, req.centre_y, req.centre_z};

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= req_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= div_v;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= sq2_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dz_s1 <= (req.dir_x == '0) && (req.dir_y == '0) && (req.dir_z == '0);
			for (int i = 0; i < 3; i++) begin
				dv_s1[i] <= dir_a[i];
				vc_s1[i] <= (W+1)'(cen_a[i]) - (W+1)'(org_a[i]);
			end

			dz_s2 <= dz_s1;
			for (int i = 0; i < 3; i++) begin
				dd_s2[i] <= dv_s1[i] * dv_s1[i];
				pv_s2[i] <= dv_s1[i] * vc_s1[i];
				vv_s2[i] <= vc_s1[i] * vc_s1[i];
			end

			dz_s3 <= dz_s2;
			d2_s3 <= dd_s2[0] + dd_s2[1] + dd_s2[2];
			p_s3  <= PW'(pv_s2[0]) + PW'(pv_s2[1]) + PW'(pv_s2[2]);
			o2_s3 <= OW'(vv_s2[0]) + OW'(vv_s2[1]) + OW'(vv_s2[2]);

			dz_s4 <= dz_s3;
			d2_s4 <= d2_s3;
			ap_s4 <= p_s3[PW-1] ? NW'(-p_s3) : NW'(p_s3);
			o2_s4 <= o2_s3;

			dz_s5 <= div_dz;
			tc_s5 <= div_q;
			t2_s5 <= div_q * div_q;
			o2_s5 <= div_o2;
			r2_s5 <= radius_q * radius_q;

			dz_s6  <= dz_s5;
			tc_s6  <= tc_s5;
			dp2_s6 <= ((2*TW)'(o2_s5) < t2_s5) ? '0 : o2_s5 - t2_s5[OW-1:0];
			r2_s6  <= r2_s5;

			dz_s7   <= dz_s6;
			tc_s7   <= tc_s6;
			hit_s7  <= CMPW'(dp2_s6) < CMPW'(r2full);
			diff_s7 <= r2full - HX'(dp2_s6);

			rsp_s8.hit          <= sq2_hit && !sq2_dz;
			rsp_s8.hit_distance <= (sq2_hit && !sq2_dz) ? res_sat[W-1:0] : MINUS_ONE;
		end
	end

	assign r2full = {r2_s6, {(2*FRAC_BITS){1'b0}}};

	rsi_isqrt #(
		.XW (2*W),
		.SW (NW + OW + 1)
	) u_rsi_isqrt_dir (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (v_s4),
		.x        (d2_s4),
		.side_in  ({ap_s4, o2_s4, dz_s4}),
		.out_v    (sq1_v),
		.root     (sq1_root),
		.side_out ({sq1_ap, sq1_o2, sq1_dz})
	);

	rsi_div #(
		.NW (NW),
		.DW (W),
		.QW (TW),
		.SW (OW + 1)
	) u_rsi_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (sq1_v),
		.n        (sq1_ap),
		.d        (sq1_root),
		.side_in  ({sq1_o2, sq1_dz}),
		.out_v    (div_v),
		.q        (div_q),
		.side_out ({div_o2, div_dz})
	);

	rsi_isqrt #(
		.XW (HX),
		.SW (TW + 2)
	) u_rsi_isqrt_chord (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (v_s7),
		.x        (diff_s7),
		.side_in  ({tc_s7, hit_s7, dz_s7}),
		.out_v    (sq2_v),
		.root     (sq2_root),
		.side_out ({sq2_tc, sq2_hit, sq2_dz})
	);

	always_comb begin
		res = $signed({1'b0, sq2_tc}) - $signed({{(TW+1-HR){1'b0}}, sq2_root});
		if (res > HI_LIM) begin
			res_sat = HI_LIM;
		end else if (res < LO_LIM) begin
			res_sat = LO_LIM;
		end else begin
			res_sat = res;
		end
	end

	// output skid register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			skid_v_q <= rsp_stall;
		end else begin
			skid_v_q <= v_s8 && rsp_stall;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q) begin
			skid_q <= rsp_s8;
		end
	end

	assign rsp_valid = skid_v_q || v_s8;
	assign rsp       = skid_v_q ? skid_q : rsp_s8;

endmodule

// ===== rtl/rsi_isqrt.sv =====
// pipelined integer square root, one result bit per stage
module rsi_isqrt #(
	parameter int XW = 64,
	parameter int SW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_v,
	input  logic [XW-1:0]   x,
	input  logic [SW-1:0]   side_in,
	output logic            out_v,
	output logic [XW/2-1:0] root,
	output logic [SW-1:0]   side_out
);
	localparam int RW = XW / 2;

	logic            v_s    [RW];
	logic [XW-1:0]   x_s    [RW];
	logic [RW+1:0]   rem_s  [RW];
	logic [RW-1:0]   root_s [RW];
	logic [SW-1:0]   side_s [RW];

	for (genvar k = 0; k < RW; k++) begin : g_stage
		logic          pv;
		logic [XW-1:0] px;
		logic [RW+1:0] prem;
		logic [RW-1:0] proot;
		logic [SW-1:0] pside;
		logic [RW+1:0] rem_n;
		logic [RW+1:0] trial;
		logic          ge;

		if (k == 0) begin : g_first
			assign pv    = in_v;
			assign px    = x;
			assign prem  = '0;
			assign proot = '0;
			assign pside = side_in;
		end else begin : g_next
			assign pv    = v_s[k-1];
			assign px    = x_s[k-1];
			assign prem  = rem_s[k-1];
			assign proot = root_s[k-1];
			assign pside = side_s[k-1];
		end

		assign rem_n = {prem[RW-1:0], px[XW-1 -: 2]};
		assign trial = {proot, 2'b01};
		assign ge    = rem_n >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[k]    <= px << 2;
				rem_s[k]  <= ge ? rem_n - trial : rem_n;
				root_s[k] <= {proot[RW-2:0], ge};
				side_s[k] <= pside;
			end
		end
	end

	assign out_v    = v_s[RW-1];
	assign root     = root_s[RW-1];
	assign side_out = side_s[RW-1];

endmodule

// ===== rtl/rsi_div.sv =====
// pipelined restoring divider with saturating quotient, one quotient bit per stage
module rsi_div #(
	parameter int NW = 65,
	parameter int DW = 32,
	parameter int QW = 34,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_v,
	input  logic [NW-1:0] n,
	input  logic [DW-1:0] d,
	input  logic [SW-1:0] side_in,
	output logic          out_v,
	output logic [QW-1:0] q,
	output logic [SW-1:0] side_out
);
	localparam int HW = NW - QW;

	logic          pre_v_s;
	logic          pre_ovf_s;
	logic [DW-1:0] pre_rem_s;
	logic [QW-1:0] pre_lo_s;
	logic [DW-1:0] pre_d_s;
	logic [SW-1:0] pre_side_s;

	logic          v_s    [QW];
	logic          ovf_s  [QW];
	logic [DW-1:0] rem_s  [QW];
	logic [QW-1:0] lo_s   [QW];
	logic [QW-1:0] q_s    [QW];
	logic [DW-1:0] d_s    [QW];
	logic [SW-1:0] side_s [QW];

	logic [DW-1:0] n_hi;
	assign n_hi = {{(DW-HW){1'b0}}, n[NW-1:QW]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_v_s <= 1'b0;
		end else if (en) begin
			pre_v_s <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pre_ovf_s  <= n_hi >= d;
			pre_rem_s  <= n_hi;
			pre_lo_s   <= n[QW-1:0];
			pre_d_s    <= d;
			pre_side_s <= side_in;
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic          pv;
		logic          povf;
		logic [DW-1:0] prem;
		logic [QW-1:0] plo;
		logic [QW-1:0] pq;
		logic [DW-1:0] pd;
		logic [SW-1:0] pside;
		logic [DW:0]   rem_n;
		logic [DW:0]   dext;
		logic [DW:0]   rem_sub;
		logic          ge;

		if (k == 0) begin : g_first
			assign pv    = pre_v_s;
			assign povf  = pre_ovf_s;
			assign prem  = pre_rem_s;
			assign plo   = pre_lo_s;
			assign pq    = '0;
			assign pd    = pre_d_s;
			assign pside = pre_side_s;
		end else begin : g_next
			assign pv    = v_s[k-1];
			assign povf  = ovf_s[k-1];
			assign prem  = rem_s[k-1];
			assign plo   = lo_s[k-1];
			assign pq    = q_s[k-1];
			assign pd    = d_s[k-1];
			assign pside = side_s[k-1];
		end

		assign rem_n   = {prem, plo[QW-1]};
		assign dext    = {1'b0, pd};
		assign ge      = rem_n >= dext;
		assign rem_sub = rem_n - dext;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ovf_s[k]  <= povf;
				rem_s[k]  <= ge ? rem_sub[DW-1:0] : rem_n[DW-1:0];
				lo_s[k]   <= plo << 1;
				q_s[k]    <= {pq[QW-2:0], ge};
				d_s[k]    <= pd;
				side_s[k] <= pside;
			end
		end
	end

	assign out_v    = v_s[QW-1];
	assign q        = ovf_s[QW-1] ? '1 : q_s[QW-1];
	assign side_out = side_s[QW-1];

endmodule

// ===== rtl/rsi_checker.sv =====
// port-level assertions for the ray sphere intersection block, with bind
`include "ray_sphere_intersection_macros.svh"

module rsi_checker #(
	parameter int FRAC_BITS = 16
) (
	input logic          clk,
	input logic          arst_n,
	input logic          req_stall,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input rsi_pkg::rsp_t rsp
);
	import rsi_pkg::*;

	localparam logic [CW-1:0] MINUS_ONE = {{(CW-FRAC_BITS){1'b1}}, {FRAC_BITS{1'b0}}};

	`RSI_ASSERT_NOW(a_miss_value, rsp_valid && !rsp.hit, rsp.hit_distance == MINUS_ONE)
	`RSI_ASSERT_NOW(a_stall_has_result, req_stall, rsp_valid)
	`RSI_ASSERT_NEXT(a_hold_valid, rsp_valid && rsp_stall, rsp_valid)
	`RSI_ASSERT_NEXT(a_hold_data, rsp_valid && rsp_stall, $stable(rsp))

endmodule

bind ray_sphere_intersection rsi_checker #(
	.FRAC_BITS (FRAC_BITS)
) u_rsi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
